### rtl/bez_pkg.sv
`timescale 1ns / 1ps

package bez_pkg;

    // Sequencer states: one multiply is issued in each of ST_TT, ST_TU, ST_TTT, ST_WX and ST_Y.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TT,
        ST_TU,
        ST_TTT,
        ST_WX,
        ST_CHK,
        ST_Y,
        ST_FIN
    } t_state;

    // Register indexes of the configuration port.
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_MAX_ITER  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [16:0] TOLERANCE_RESET = 17'd655;
    localparam logic [4:0]  MAX_ITER_RESET  = 5'd5;

endpackage

### rtl/bez_mul.sv
`timescale 1ns / 1ps

// Shared fixed-point multiplier: registers (a * b) >> FRAC_BITS when enabled.
// Both operands are at most one, so the kept product fits FRAC_BITS+1 bits.
module bez_mul
    import bez_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS:0]   i_op_a,
    input  logic [FRAC_BITS:0]   i_op_b,
    output logic [FRAC_BITS:0]   o_prod
);

    localparam int PW = 2 * FRAC_BITS + 2;

    logic [PW-1:0]      w_full;
    logic [FRAC_BITS:0] r_prod;

    // Full product, then truncation to the fraction width.
    assign w_full = PW'(i_op_a) * PW'(i_op_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/bezier_ease_y_for_x.sv
`timescale 1ns / 1ps

// Cubic Bezier easing: returns y for a target x on the curve with inner
// control points (a, 1-a). An input word carries x_target and curve_shape,
// both unsigned fixed point; it is accepted when i_in_valid and o_in_ready
// are high at a clock edge. The block bisects t for at most max_iterations
// steps (clamped to 1..16), stopping early once |x(t) - x_target| <
// tolerance, and returns one output word with y_value and converged.
// Each bisection step uses the single shared multiplier in turn for t*t,
// t*(1-t), t^3 and a*t*(1-t), then does the compare. The default limit is
// 5 steps. One word is worked on at a time; o_in_ready is high only while
// the sequencer is idle.
// The result sits in an output register, so a new word may be accepted
// while the previous result waits for i_out_ready. If the receiver stalls
// past that, the finished result is held inside until the register frees.
// Reset (synchronous, active low) returns the sequencer to idle, drops
// o_out_valid and loads tolerance = 655 and max_iterations = 5.
// Configuration goes through the APB port: tolerance at 0, max_iterations
// at 4. Writes are expected only while the block is idle.
module bezier_ease_y_for_x
    import bez_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_x_target,
    input  logic [15:0] i_curve_shape,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [16:0] o_y_value,
    output logic        o_converged,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int                 VW  = FRAC_BITS + 1;
    localparam int                 XW  = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
    localparam int                 AW  = (VW > 16) ? VW : 16;
    localparam logic [FRAC_BITS:0] ONE = VW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] HALF = VW'(1) << (FRAC_BITS - 1);

    t_state r_state, n_state;

    logic [16:0]        r_tolerance;
    logic [4:0]         r_max_iter;
    logic [FRAC_BITS:0] r_a, r_b, r_low, r_high, r_mid, r_tt, r_tu, r_ttt;
    logic [15:0]        r_target;
    logic [3:0]         r_iter, r_lim_m1;
    logic               r_conv;
    logic               r_out_valid;
    logic [16:0]        r_y_value;
    logic               r_converged;

    logic               w_mul_en;
    logic [FRAC_BITS:0] w_op_a, w_op_b, w_prod;
    logic [AW-1:0]      w_a_ext;
    logic [FRAC_BITS:0] w_a_sat;
    logic [3:0]         w_lim_m1;
    logic [XW-1:0]      w_curve, w_target, w_tol, w_diff;
    logic               w_below, w_hit, w_last, w_out_free, w_cfg_wr;
    logic [FRAC_BITS+1:0] w_sum_up, w_sum_dn;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOLERANCE_RESET;
            r_max_iter  <= MAX_ITER_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_TOLERANCE: r_tolerance <= pwdata[16:0];
                REG_MAX_ITER:  r_max_iter  <= pwdata[4:0];
                default:       r_tolerance <= r_tolerance;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TOLERANCE: prdata = {15'd0, r_tolerance};
            REG_MAX_ITER:  prdata = {27'd0, r_max_iter};
            default:       prdata = 32'd0;
        endcase
    end

    // Shape value saturated to one, and the step limit clamped to 1..16.
    assign w_a_ext = AW'(i_curve_shape);
    assign w_a_sat = (w_a_ext > AW'(ONE)) ? ONE : w_a_ext[FRAC_BITS:0];

    always_comb begin
        priority if (r_max_iter == 5'd0) begin
            w_lim_m1 = 4'd0;
        end else if (r_max_iter > 5'd16) begin
            w_lim_m1 = 4'd15;
        end else begin
            w_lim_m1 = 4'(r_max_iter - 5'd1);
        end
    end

    // Curve value from the last product: 3 * (w * t * (1-t)) + t^3.
    assign w_curve  = XW'(3) * XW'(w_prod) + XW'(r_ttt);
    assign w_target = XW'(r_target);
    assign w_tol    = XW'(r_tolerance);
    assign w_below  = w_curve < w_target;
    assign w_diff   = w_below ? (w_target - w_curve) : (w_curve - w_target);
    assign w_hit    = w_diff < w_tol;
    assign w_last   = r_iter == r_lim_m1;
    assign w_sum_up = (FRAC_BITS + 2)'(r_mid) + (FRAC_BITS + 2)'(r_high);
    assign w_sum_dn = (FRAC_BITS + 2)'(r_low) + (FRAC_BITS + 2)'(r_mid);

    assign w_out_free = !r_out_valid || i_out_ready;

    // Shared multiplier.
    bez_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_TT;
            ST_TT:   n_state = ST_TU;
            ST_TU:   n_state = ST_TTT;
            ST_TTT:  n_state = ST_WX;
            ST_WX:   n_state = ST_CHK;
            ST_CHK:  n_state = (w_hit || w_last) ? ST_Y : ST_TT;
            ST_Y:    n_state = ST_FIN;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Multiplier issue and handshake outputs.
    always_comb begin
        w_mul_en   = 1'b0;
        w_op_a     = r_mid;
        w_op_b     = r_mid;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_TT:   w_mul_en = 1'b1;
            ST_TU: begin
                w_mul_en = 1'b1;
                w_op_b   = ONE - r_mid;
            end
            ST_TTT: begin
                w_mul_en = 1'b1;
                w_op_a   = r_tt;
            end
            ST_WX: begin
                w_mul_en = 1'b1;
                w_op_a   = r_a;
                w_op_b   = r_tu;
            end
            ST_Y: begin
                w_mul_en = 1'b1;
                w_op_a   = r_b;
                w_op_b   = r_tu;
            end
            ST_CHK, ST_FIN: w_mul_en = 1'b0;
            default: w_mul_en = 1'b0;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_a      <= w_a_sat;
                r_b      <= ONE - w_a_sat;
                r_target <= i_x_target;
                r_low    <= '0;
                r_high   <= ONE;
                r_mid    <= HALF;
                r_iter   <= 4'd0;
                r_lim_m1 <= w_lim_m1;
                r_conv   <= 1'b0;
            end
            ST_TU:  r_tt  <= w_prod;
            ST_TTT: r_tu  <= w_prod;
            ST_WX:  r_ttt <= w_prod;
            ST_CHK: begin
                if (w_hit) begin
                    r_conv <= 1'b1;
                end else if (!w_last) begin
                    r_iter <= r_iter + 4'd1;
                    if (w_below) begin
                        r_low <= r_mid;
                        r_mid <= w_sum_up[FRAC_BITS+1:1];
                    end else begin
                        r_high <= r_mid;
                        r_mid  <= w_sum_dn[FRAC_BITS+1:1];
                    end
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    r_y_value   <= w_curve[16:0];
                    r_converged <= r_conv;
                end
            end
            ST_TT, ST_Y: r_iter <= r_iter;
            default:     r_iter <= r_iter;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_y_value   = r_y_value;
    assign o_converged = r_converged;

endmodule
